// ===== design/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and constants of the sharded key set: field widths and the
// operation codes carried on the request channel.
// ----------------------------------------------------------------------------
package sks_pkg;

   localparam int KEY_W = 31;
   localparam int OP_W  = 2;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [OP_W-1:0]  op_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_SEARCH = 2'd1;
   localparam op_type OP_DELETE = 2'd2;

endpackage

// ===== design/sks_if.sv =====
// ----------------------------------------------------------------------------
// sks_if
// Valid/ready channels of the sharded key set: the request channel carries
// an operation and a key, the response channel the found and full flags.
// ----------------------------------------------------------------------------
interface sks_req_if
   import sks_pkg::*;
   ();
   logic    valid;
   logic    ready;
   op_type  operation;
   key_type key;

   modport source (output valid, output operation, output key, input ready);
   modport sink   (input valid, input operation, input key, output ready);
endinterface

interface sks_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic bank_full;

   modport source (output valid, output found, output bank_full, input ready);
   modport sink   (input valid, input found, input bank_full, output ready);
endinterface

// ===== design/sharded_key_set_top.sv =====
// ----------------------------------------------------------------------------
// sharded_key_set_top
// Multiset of 31-bit keys spread over SHARDS banks by key modulo SHARDS,
// each bank a packed list with a fill count, held in one key memory.
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction carries an operation (insert, search,
//   delete first match) and a key. req.ready is high only while the
//   sequencer is idle; one transaction is worked on at a time.
//   rsp channel: exactly one transaction per request, with found (search or
//   delete hit) and bank_full (insert refused because the bank was full).
//   after a request is accepted, the bank select waits on the residue unit
//   and then on the dispatch state; insert and the unused code go straight
//   on to the response; search reads the addressed bank up to its first
//   match or its fill count; delete scans to the first match, then shifts
//   the tail down one entry per cycle through the one read and the one
//   write port, or on a miss scans the whole bank.
//   req.ready rises together with rsp.valid; the scan reads the next entry
//   while it compares the last, and the shift writes one entry back while
//   it reads the next.
//   reset clears the fill counts, so every bank starts empty; the key memory
//   itself is not cleared since only entries below a fill count are read.
//   the response sits in an output register; while the receiver stalls the
//   next request is still accepted and worked on, and the sequencer waits
//   in its response state only if the older response has not been taken.
// ----------------------------------------------------------------------------
module sharded_key_set_top
   import sks_pkg::*;
#(
   parameter int SHARDS     = 4,
   parameter int BANK_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   sks_req_if.sink    req,
   sks_rsp_if.source  rsp
);

   localparam int BW    = (SHARDS > 1) ? $clog2(SHARDS) : 1;      // bank select
   localparam int IW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1; // entry index
   localparam int FW    = $clog2(BANK_DEPTH + 1);                 // fill count
   localparam int DEPTH = SHARDS * BANK_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // one-hot sequencer
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MOD   = 6'b000010,
      S_DISP  = 6'b000100,
      S_SCAN  = 6'b001000,
      S_SHIFT = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   key_type       key_ff, key_in;
   logic [BW-1:0] bank_ff, bank_in;
   logic [AW-1:0] base_ff, base_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] scan_ff, scan_in;   // next entry to read
   logic [FW-1:0] cmp_ff, cmp_in;     // entry that rd_data_ff holds
   logic          pend_ff, pend_in;   // rd_data_ff holds a fresh read
   logic          found_ff, found_in;
   logic          full_ff, full_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic          rsp_full_ff, rsp_full_in;

   // per-bank fill counts
   logic [FW-1:0] fill_cnt_ff [SHARDS];
   logic          fill_we;
   logic [FW-1:0] fill_wdata;

   // key memory, one write and one read port, registered read data
   key_type       key_store_ff [DEPTH];
   key_type       rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   key_type       wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   // residue unit
   logic          mod_start;
   logic          mod_done;
   logic [BW-1:0] residue;

   logic          hit;
   logic [FW-1:0] shift_dst;

   sks_mod_unit #(
      .DIVISOR (SHARDS)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .key     (req.key),
      .done    (mod_done),
      .residue (residue)
   );

   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.found     = rsp_found_ff;
   assign rsp.bank_full = rsp_full_ff;

   assign hit       = pend_ff && (rd_data_ff == key_ff);
   assign shift_dst = cmp_ff - FW'(1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      bank_in      = bank_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      cmp_in       = cmp_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      mod_start    = 1'b0;
      fill_we      = 1'b0;
      fill_wdata   = fill_ff;
      wr_en        = 1'b0;
      wr_addr      = base_ff + AW'(fill_ff[IW-1:0]);
      wr_data      = key_ff;
      rd_en        = 1'b0;
      rd_addr      = base_ff + AW'(scan_ff[IW-1:0]);

      // response taken by the receiver
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in     = req.operation;
               key_in    = req.key;
               mod_start = 1'b1;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               bank_in  = residue;
               base_in  = AW'(residue) * AW'(BANK_DEPTH);
               fill_in  = fill_cnt_ff[residue];
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            found_in = 1'b0;
            full_in  = 1'b0;
            scan_in  = '0;
            cmp_in   = '0;
            pend_in  = 1'b0;
            case (op_ff)
               OP_INSERT: begin
                  if (fill_ff == FW'(BANK_DEPTH)) begin
                     full_in = 1'b1;
                  end else begin
                     // append at the end of the packed list
                     wr_en      = 1'b1;
                     fill_we    = 1'b1;
                     fill_wdata = fill_ff + FW'(1);
                  end
                  state_in = S_RESP;
               end
               OP_SEARCH, OP_DELETE: begin
                  state_in = S_SCAN;
               end
               default: begin
                  // unused code: no change, both flags low
                  state_in = S_RESP;
               end
            endcase
         end
         S_SCAN: begin
            // read issued in the cycle before its compare
            if (hit) begin
               found_in = 1'b1;
               if (op_ff == OP_DELETE) begin
                  scan_in  = cmp_ff + FW'(1);
                  pend_in  = 1'b0;
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_RESP;
               end
            end else if (scan_ff == fill_ff) begin
               state_in = S_RESP;
            end else begin
               rd_en   = 1'b1;
               cmp_in  = scan_ff;
               scan_in = scan_ff + FW'(1);
               pend_in = 1'b1;
            end
         end
         S_SHIFT: begin
            // entry read last cycle moves down one place
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = base_ff + AW'(shift_dst[IW-1:0]);
               wr_data = rd_data_ff;
            end
            if (scan_ff == fill_ff) begin
               fill_we    = 1'b1;
               fill_wdata = fill_ff - FW'(1);
               state_in   = S_RESP;
            end else begin
               rd_en   = 1'b1;
               cmp_in  = scan_ff;
               scan_in = scan_ff + FW'(1);
               pend_in = 1'b1;
            end
         end
         S_RESP: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_full_in  = full_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      bank_ff      <= bank_in;
      base_ff      <= base_in;
      fill_ff      <= fill_in;
      scan_ff      <= scan_in;
      cmp_ff       <= cmp_in;
      found_ff     <= found_in;
      full_ff      <= full_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

   // fill counts: every bank empty after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SHARDS; i++) begin
            fill_cnt_ff[i] <= '0;
         end
      end else if (fill_we) begin
         fill_cnt_ff[bank_ff] <= fill_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= key_store_ff[rd_addr];
      end
   end

endmodule

// ===== design/sks_mod_unit.sv =====
// ----------------------------------------------------------------------------
// sks_mod_unit
// Residue of a key by a constant divisor through a reciprocal multiply:
// quotient from the high product bits, residue from the low bits of
// key minus quotient times divisor. Key, product and residue are registered
// in turn, the key also feeding the residue, so it takes one key at a time.
module sks_mod_unit
   import sks_pkg::*;
#(
   parameter int DIVISOR = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  key_type                                  key,
   output logic                                     done,
   output logic [(DIVISOR > 1 ? $clog2(DIVISOR) : 1)-1:0] residue
);

   localparam int RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
   localparam int SH = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;   // extra shift
   localparam int MW = 32;                                     // reciprocal width
   localparam int PW = KEY_W + MW;
   // ceil(2^(KEY_W+SH) / DIVISOR): exact quotient for every key value
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << (KEY_W + SH)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [MW-1:0] RECIP  = MW'(RECIP_WIDE);
   localparam logic [RW-1:0] DIV_LO = RW'(DIVISOR);

   key_type       key_ff, key_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] quot_lo;
   logic          s1_ff, s2_ff, done_ff;   // stage valids

   assign key_in  = start ? key : key_ff;
   assign prod_in = PW'(key_ff) * PW'(RECIP);
   assign quot_lo = prod_ff[KEY_W+SH +: RW];
   // residue is below the divisor, so its low bits are the whole value
   assign rem_in  = key_ff[RW-1:0] - RW'(quot_lo * DIV_LO);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= start;
         s2_ff   <= s1_ff;
         done_ff <= s2_ff;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done    = done_ff;
   assign residue = rem_ff;

endmodule

// ===== design/sks_checker.sv =====
// ----------------------------------------------------------------------------
// sks_checker
// Port-level checks of the sharded key set, attached to the top level.
// ----------------------------------------------------------------------------
module sks_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic rsp_bank_full
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a response never reports both a hit and a full bank
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_bank_full))
      else $error("found and bank_full both set");

   // one request at a time: busy right after an accepted request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // the bank select waits on the residue unit: no response right after a request
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 !(rsp_valid && !$past(rsp_valid)))
      else $error("response too soon after request");

endmodule

bind sharded_key_set_top sks_checker u_sks_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_found     (rsp.found),
   .rsp_bank_full (rsp.bank_full)
);

// ===== tb/sharded_key_set_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sharded_key_set_top_tb
// Self-checking bench for the sharded key set. A shadow copy of the banks
// predicts found and bank_full for every request, and each response is
// compared in order. Directed tests cover key extremes, duplicates, misses,
// the unused operation code and a bank filled to its depth. Random phases
// with and without idling follow, plus a long response stall.
// ----------------------------------------------------------------------------
module sharded_key_set_top_tb
   import sks_pkg::*;
   ();

   localparam int SHARDS      = 4;
   localparam int BANK_DEPTH  = 128;
   localparam int CYCLE_LIMIT = 1_000_000;
   // worst response is a delete that scans and shifts a whole bank
   localparam int END_SLACK   = 2 * (40 + BANK_DEPTH);
   localparam int POOL_SIZE   = 24;
   localparam op_type OP_UNUSED = 2'd3;
   localparam key_type KEY_MAX  = {KEY_W{1'b1}};

   typedef struct {
      op_type  op;
      key_type key;
      logic    found;
      logic    bank_full;
   } outcome_type;

   logic clock;
   logic reset;

   sks_req_if req_ch ();
   sks_rsp_if rsp_ch ();

   sharded_key_set_top #(
      .SHARDS     (SHARDS),
      .BANK_DEPTH (BANK_DEPTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // shadow copy of the banks, same packed layout as the block
   key_type shadow_store [SHARDS*BANK_DEPTH];
   int      shadow_fill  [SHARDS];

   // predicted outcomes in request order
   outcome_type pending_outcomes [$];

   int error_count = 0;
   int cycle_count = 0;
   int rsp_taken = 0;          // responses accepted so far
   int rsp_hold_request = 0;   // long stall handed to the receiver process
   bit req_idle;               // sender draws random gaps
   bit rsp_idle;               // receiver draws random stalls

   key_type key_pool [POOL_SIZE];

   // ------------------------------------------------------------------
   // clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
   end

   // run-length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d responses outstanding",
                cycle_count, pending_outcomes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // predictor: applies one operation to the shadow banks
   // ------------------------------------------------------------------
   function automatic outcome_type apply_operation(op_type op, key_type key);
      outcome_type res;
      int bank;
      int base;
      int fill;
      int hit;
      int i;
      res.op        = op;
      res.key       = key;
      res.found     = 1'b0;
      res.bank_full = 1'b0;
      bank = int'(key % SHARDS);
      base = bank * BANK_DEPTH;
      fill = shadow_fill[bank];
      // first matching position, or fill when the key is absent
      hit = fill;
      for (i = fill - 1; i >= 0; i--) begin
         if (shadow_store[base + i] == key) hit = i;
      end
      case (op)
         OP_INSERT: begin
            if (fill >= BANK_DEPTH) begin
               res.bank_full = 1'b1;
            end else begin
               shadow_store[base + fill] = key;
               shadow_fill[bank] = fill + 1;
            end
         end
         OP_SEARCH: begin
            res.found = (hit < fill);
         end
         OP_DELETE: begin
            if (hit < fill) begin
               for (i = hit; i + 1 < fill; i++) begin
                  shadow_store[base + i] = shadow_store[base + i + 1];
               end
               shadow_fill[bank] = fill - 1;
               res.found = 1'b1;
            end
         end
         default: begin
            // unused code leaves the banks alone
         end
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offers one transaction and waits until it is accepted; valid stays
   // high afterwards so back-to-back requests need no extra edge
   task automatic send_item(op_type op, key_type key);
      int gap;
      gap = req_idle ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.key       <= key;
      do @(posedge clock); while (!req_ch.ready);
      pending_outcomes.push_back(apply_operation(op, key));
   endtask

   // sender goes quiet until every predicted response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // response side: ready with random stalls, long hold counted here
   // ------------------------------------------------------------------
   initial begin : rsp_driver
      int gap_left;
      int hold_left;
      int hold_seen;
      int seen;
      gap_left  = 0;
      hold_left = 0;
      hold_seen = 0;
      seen      = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request != hold_seen) begin
            hold_left = rsp_hold_request;
            hold_seen = rsp_hold_request;
         end
         // a transaction went through at the last edge: draw the next stall
         if (rsp_taken != seen) begin
            seen     = rsp_taken;
            gap_left = rsp_idle ? $urandom_range(0, 15) : 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_ch.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // checker: every accepted response against the oldest prediction
   always @(posedge clock) begin : rsp_checker
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_taken <= rsp_taken + 1;
         if (pending_outcomes.size() == 0) begin
            $error("response with nothing outstanding: found %0b bank_full %0b",
                   rsp_ch.found, rsp_ch.bank_full);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.found !== want.found) begin
               $error("found (op %0d key %h): expected %0b, actual %0b",
                      want.op, want.key, want.found, rsp_ch.found);
               error_count++;
            end
            if (rsp_ch.bank_full !== want.bank_full) begin
               $error("bank_full (op %0d key %h): expected %0b, actual %0b",
                      want.op, want.key, want.bank_full, rsp_ch.bank_full);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // each operation, key extremes, duplicates, misses and the unused code
   task automatic test_basic_ops();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      send_item(OP_INSERT, '0);
      send_item(OP_SEARCH, '0);
      send_item(OP_SEARCH, key_type'(4));      // same bank, not there
      send_item(OP_DELETE, key_type'(4));      // delete of a missing key
      send_item(OP_INSERT, KEY_MAX);
      send_item(OP_SEARCH, KEY_MAX);
      // duplicates: delete removes only the first copy
      send_item(OP_INSERT, key_type'(5));
      send_item(OP_INSERT, key_type'(5));
      send_item(OP_INSERT, key_type'(9));
      send_item(OP_DELETE, key_type'(5));
      send_item(OP_SEARCH, key_type'(5));
      send_item(OP_DELETE, key_type'(5));
      send_item(OP_SEARCH, key_type'(5));
      send_item(OP_SEARCH, key_type'(9));
      send_item(OP_DELETE, key_type'(9));
      // unused operation code must not touch the bank
      send_item(OP_UNUSED, KEY_MAX);
      send_item(OP_SEARCH, KEY_MAX);
      send_item(OP_DELETE, KEY_MAX);
      send_item(OP_DELETE, '0);
      send_item(OP_SEARCH, '0);
      send_item(OP_INSERT, key_type'(31'h2AAA_AAAA));
      send_item(OP_INSERT, key_type'(31'h5555_5555));
      send_item(OP_SEARCH, key_type'(31'h2AAA_AAAA));
      send_item(OP_SEARCH, key_type'(31'h5555_5555));
      send_item(OP_UNUSED, '0);
   endtask

   // fill a bank to depth, overflow it, delete the added keys in random order
   task automatic test_full_bank();
      key_type filled [$];
      key_type k;
      key_type tmp;
      int need;
      int i;
      int j;
      req_idle = 1'b0;
      rsp_idle = 1'b1;
      need = BANK_DEPTH - shadow_fill[2];
      for (i = 0; i < need; i++) begin
         k = key_type'({$urandom(), 2'b10});
         filled.push_back(k);
         send_item(OP_INSERT, k);
      end
      send_item(OP_INSERT, key_type'(31'h0000_0006));  // refused, bank is full
      send_item(OP_SEARCH, filled[filled.size()-1]);     // hit at the last entry
      send_item(OP_SEARCH, key_type'(31'h7FFF_FFFE));    // miss over a full bank
      // delete near the head shifts almost the whole bank
      send_item(OP_DELETE, filled[0]);
      k = key_type'(31'h7FFF_FFFE);
      filled[0] = k;
      send_item(OP_INSERT, k);
      send_item(OP_INSERT, key_type'(31'h0000_0002));  // full again
      // shuffle and drain
      for (i = filled.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = filled[i];
         filled[i] = filled[j];
         filled[j] = tmp;
      end
      req_idle = 1'b1;
      for (i = 0; i < filled.size(); i++) begin
         send_item(OP_DELETE, filled[i]);
      end
      send_item(OP_SEARCH, filled[0]);
      wait_drained();
   endtask

   // receiver holds off for a long stretch while requests keep coming, so
   // the output register and the sequencer fill and req.ready drops
   task automatic test_backpressure();
      int i;
      wait_drained();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      rsp_hold_request = 400;
      for (i = 0; i < 10; i++) begin
         send_item(op_type'($urandom_range(0, 2)), key_pool[$urandom_range(0, 7)]);
      end
      // sender pauses until everything came back
      wait_drained();
   endtask

   function automatic key_type pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 80) return (r < 78) ? KEY_MAX : key_type'(0);
      return key_type'($urandom());
   endfunction

   function automatic op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return OP_INSERT;
      if (r < 70) return OP_SEARCH;
      if (r < 95) return OP_DELETE;
      return OP_UNUSED;
   endfunction

   // random traffic in phases; the first runs flat out on both sides
   task automatic test_random();
      int phase;
      int i;
      for (phase = 0; phase < 6; phase++) begin
         req_idle = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1) | (phase == 3));
         rsp_idle = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1) | (phase == 3));
         for (i = 0; i < 50; i++) begin
            send_item(pick_op(), pick_key());
         end
         if (phase == 2 || phase == 4) wait_drained();
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main
      int i;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_INSERT;
      req_ch.key       <= '0;
      req_idle         = 1'b1;
      rsp_idle         = 1'b1;
      // block starts with every bank empty
      for (i = 0; i < SHARDS; i++) shadow_fill[i] = 0;
      for (i = 0; i < SHARDS*BANK_DEPTH; i++) shadow_store[i] = '0;
      // key pool spread over the banks, a few sharing the low bits
      for (i = 0; i < POOL_SIZE; i++) key_pool[i] = key_type'($urandom());
      key_pool[0] = '0;
      key_pool[1] = KEY_MAX;
      key_pool[2] = key_type'(1);
      key_pool[3] = key_type'(2);

      while (reset) @(posedge clock);

      test_basic_ops();
      test_full_bank();
      test_backpressure();
      test_random();

      // all accepted: wait for the last responses, then watch for strays
      wait_drained();
      repeat (END_SLACK) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sks_pkg.sv
design/sks_if.sv
design/sks_mod_unit.sv
design/sharded_key_set_top.sv
design/sks_checker.sv
tb/sharded_key_set_top_tb.sv
